// ===== rtl/bftf_pkg.sv =====
// Shared types, constants and helpers for the body frame tracking feedback block.
`default_nettype none
package bftf_pkg;

  localparam int unsigned NumGains   = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned CordicW    = 34;   // Q2.30 plus growth headroom
  localparam int unsigned AngW       = 28;   // angle accumulator, 2^-24 rad

  localparam logic signed [16:0] PiQ13     = 17'sd25736;
  localparam logic signed [17:0] TwoPiQ13  = 18'sd51472;
  localparam logic signed [16:0] HalfPiQ13 = 17'sd12868;
  localparam logic signed [CordicW-1:0] CordicKQ30 = 34'sd652032874;

  // Gain register indexes.
  localparam logic [CfgIdxW-1:0] GainLinFwd = 3'd0;
  localparam logic [CfgIdxW-1:0] GainLinLat = 3'd1;
  localparam logic [CfgIdxW-1:0] GainLinHdg = 3'd2;
  localparam logic [CfgIdxW-1:0] GainAngFwd = 3'd3;
  localparam logic [CfgIdxW-1:0] GainAngLat = 3'd4;
  localparam logic [CfgIdxW-1:0] GainAngHdg = 3'd5;

  typedef struct packed {
    logic signed [31:0] nominal_x;
    logic signed [31:0] nominal_y;
    logic signed [15:0] nominal_heading;
    logic signed [31:0] actual_x;
    logic signed [31:0] actual_y;
    logic signed [15:0] actual_heading;
    logic signed [31:0] nominal_linear;
    logic signed [31:0] nominal_angular;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] corrected_linear;
    logic signed [31:0] corrected_angular;
    logic signed [31:0] forward_error;
    logic signed [31:0] lateral_error;
    logic signed [15:0] heading_error;
  } out_beat_t;

  // Sideband carried alongside the rotator.
  typedef struct packed {
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [15:0] dh;
    logic               neg;
    logic signed [31:0] nl;
    logic signed [31:0] na;
  } side_t;

  // Body errors handed to the gain stage.
  typedef struct packed {
    logic signed [31:0] ef;
    logic signed [31:0] el;
    logic signed [15:0] dh;
    logic signed [31:0] nl;
    logic signed [31:0] na;
  } err_t;

  function automatic logic signed [AngW-1:0] atan_lut(input int unsigned idx);
    logic signed [AngW-1:0] r;
    unique case (idx)
      0:  r = 28'sd13176795;
      1:  r = 28'sd7778716;
      2:  r = 28'sd4110060;
      3:  r = 28'sd2086331;
      4:  r = 28'sd1047214;
      5:  r = 28'sd524117;
      6:  r = 28'sd262123;
      7:  r = 28'sd131069;
      8:  r = 28'sd65536;
      9:  r = 28'sd32768;
      10: r = 28'sd16384;
      11: r = 28'sd8192;
      12: r = 28'sd4096;
      13: r = 28'sd2048;
      14: r = 28'sd1024;
      15: r = 28'sd512;
      16: r = 28'sd256;
      17: r = 28'sd128;
      18: r = 28'sd64;
      19: r = 28'sd32;
      20: r = 28'sd16;
      21: r = 28'sd8;
      22: r = 28'sd4;
      23: r = 28'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Clamp a wide signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    logic signed [31:0] r;
    if (v > 80'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -80'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bftf_stream_if.sv =====
// Valid/ready stream channel carrying one payload beat.
`default_nettype none
interface bftf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/bftf_cordic.sv =====
// Input stage (differences, heading wrap, quadrant fold) and pipelined CORDIC rotator.
`default_nettype none
module bftf_cordic (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             valid_i,
  output logic                            ready_o,
  input  bftf_pkg::in_beat_t              beat_i,
  output logic                            valid_o,
  input  wire                             ready_i,
  output logic signed [bftf_pkg::CordicW-1:0] cos_o,
  output logic signed [bftf_pkg::CordicW-1:0] sin_o,
  output bftf_pkg::side_t                 side_o
);
  import bftf_pkg::*;

  localparam int unsigned NStg = CordicSteps + 1;

  logic [NStg-1:0] v_q;
  logic [NStg:0]   rdy;

  logic signed [CordicW-1:0] x_q [NStg];
  logic signed [CordicW-1:0] y_q [NStg];
  logic signed [AngW-1:0]    z_q [NStg];
  side_t                     s_q [NStg];

  always_comb begin
    rdy[NStg] = ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NStg; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // front stage
  logic signed [16:0] dh_raw, dh_w, ah, a_fold;
  logic               fold;
  side_t              s0;

  always_comb begin
    dh_raw = 17'(beat_i.nominal_heading) - 17'(beat_i.actual_heading);
    if (dh_raw > PiQ13) begin
      dh_w = 17'(18'(dh_raw) - TwoPiQ13);
    end else if (dh_raw < -PiQ13) begin
      dh_w = 17'(18'(dh_raw) + TwoPiQ13);
    end else begin
      dh_w = dh_raw;
    end
    ah = 17'(beat_i.actual_heading);
    fold = 1'b0;
    a_fold = ah;
    if (ah > HalfPiQ13) begin
      a_fold = ah - PiQ13;
      fold   = 1'b1;
    end else if (ah < -HalfPiQ13) begin
      a_fold = ah + PiQ13;
      fold   = 1'b1;
    end
    s0.dx  = 33'(beat_i.nominal_x) - 33'(beat_i.actual_x);
    s0.dy  = 33'(beat_i.nominal_y) - 33'(beat_i.actual_y);
    s0.dh  = dh_w[15:0];
    s0.neg = fold;
    s0.nl  = beat_i.nominal_linear;
    s0.na  = beat_i.nominal_angular;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      x_q[0] <= CordicKQ30;
      y_q[0] <= '0;
      z_q[0] <= {a_fold, 11'b0};
      s_q[0] <= s0;
    end
  end

  // one rotation per stage
  for (genvar k = 1; k < NStg; k++) begin : g_rot
    localparam int unsigned I = k - 1;
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        s_q[k] <= s_q[k-1];
        if (!z_q[k-1][AngW-1]) begin
          x_q[k] <= x_q[k-1] - (y_q[k-1] >>> I);
          y_q[k] <= y_q[k-1] + (x_q[k-1] >>> I);
          z_q[k] <= z_q[k-1] - atan_lut(I);
        end else begin
          x_q[k] <= x_q[k-1] + (y_q[k-1] >>> I);
          y_q[k] <= y_q[k-1] - (x_q[k-1] >>> I);
          z_q[k] <= z_q[k-1] + atan_lut(I);
        end
      end
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NStg-1];
  assign cos_o   = x_q[NStg-1];
  assign sin_o   = y_q[NStg-1];
  assign side_o  = s_q[NStg-1];

endmodule
`default_nettype wire

// ===== rtl/bftf_rotate.sv =====
// Rotates the world position error into the body frame, rounds and saturates.
`default_nettype none
module bftf_rotate (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 valid_i,
  output logic                                ready_o,
  input  wire signed [bftf_pkg::CordicW-1:0]  cos_i,
  input  wire signed [bftf_pkg::CordicW-1:0]  sin_i,
  input  bftf_pkg::side_t                     side_i,
  output logic                                valid_o,
  input  wire                                 ready_i,
  output bftf_pkg::err_t                      err_o
);
  import bftf_pkg::*;

  localparam int unsigned PW = CordicW + 33;

  logic [1:0] v_q;
  logic [2:0] rdy;

  logic signed [PW-1:0] cx_q, sy_q, cy_q, sx_q;
  logic signed [15:0]   dh_q;
  logic signed [31:0]   nl_q, na_q;
  err_t                 e_q;

  logic signed [CordicW-1:0] c, s;
  logic signed [PW:0]        fwd, lat;

  always_comb begin
    rdy[2] = ready_i;
    rdy[1] = !v_q[1] || rdy[2];
    rdy[0] = !v_q[0] || rdy[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  // undo the quadrant fold, then multiply
  assign c = side_i.neg ? -cos_i : cos_i;
  assign s = side_i.neg ? -sin_i : sin_i;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      cx_q <= c * side_i.dx;
      sy_q <= s * side_i.dy;
      cy_q <= c * side_i.dy;
      sx_q <= s * side_i.dx;
      dh_q <= side_i.dh;
      nl_q <= side_i.nl;
      na_q <= side_i.na;
    end
  end

  // round half up at bit 30
  assign fwd = (PW+1)'(cx_q) + (PW+1)'(sy_q) + (PW+1)'(68'sd536870912);
  assign lat = (PW+1)'(cy_q) - (PW+1)'(sx_q) + (PW+1)'(68'sd536870912);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      e_q.ef <= sat32(80'(fwd >>> 30));
      e_q.el <= sat32(80'(lat >>> 30));
      e_q.dh <= dh_q;
      e_q.nl <= nl_q;
      e_q.na <= na_q;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[1];
  assign err_o   = e_q;

endmodule
`default_nettype wire

// ===== rtl/bftf_gain.sv =====
// Applies the 2x3 gain matrix and adds the correction to the nominal controls.
`default_nettype none
module bftf_gain (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                valid_i,
  output logic               ready_o,
  input  bftf_pkg::err_t     err_i,
  input  wire signed [31:0]  gain_i [bftf_pkg::NumGains],
  output logic               valid_o,
  input  wire                ready_i,
  output bftf_pkg::out_beat_t beat_o
);
  import bftf_pkg::*;

  logic [1:0] v_q;
  logic [2:0] rdy;

  logic signed [63:0] m_lf, m_ll, m_af, m_al;
  logic signed [47:0] m_lh, m_ah;

  logic signed [47:0] t_lf_q, t_ll_q, t_af_q, t_al_q;
  logic signed [34:0] t_lh_q, t_ah_q;
  err_t               e_q;
  out_beat_t          o_q;

  logic signed [50:0] lin, ang;

  always_comb begin
    rdy[2] = ready_i;
    rdy[1] = !v_q[1] || rdy[2];
    rdy[0] = !v_q[0] || rdy[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
    end
  end

  assign m_lf = gain_i[GainLinFwd] * err_i.ef;
  assign m_ll = gain_i[GainLinLat] * err_i.el;
  assign m_lh = gain_i[GainLinHdg] * err_i.dh;
  assign m_af = gain_i[GainAngFwd] * err_i.ef;
  assign m_al = gain_i[GainAngLat] * err_i.el;
  assign m_ah = gain_i[GainAngHdg] * err_i.dh;

  // floor shifts: Q16.16 by 16, Q3.13 heading by 13
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      t_lf_q <= m_lf[63:16];
      t_ll_q <= m_ll[63:16];
      t_lh_q <= m_lh[47:13];
      t_af_q <= m_af[63:16];
      t_al_q <= m_al[63:16];
      t_ah_q <= m_ah[47:13];
      e_q    <= err_i;
    end
  end

  assign lin = 51'(e_q.nl) + 51'(t_lf_q) + 51'(t_ll_q) + 51'(t_lh_q);
  assign ang = 51'(e_q.na) + 51'(t_af_q) + 51'(t_al_q) + 51'(t_ah_q);

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      o_q.corrected_linear  <= sat32(80'(lin));
      o_q.corrected_angular <= sat32(80'(ang));
      o_q.forward_error     <= e_q.ef;
      o_q.lateral_error     <= e_q.el;
      o_q.heading_error     <= e_q.dh;
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[1];
  assign beat_o  = o_q;

endmodule
`default_nettype wire

// ===== rtl/body_frame_tracking_feedback_top.sv =====
// Top level of the body frame tracking feedback controller.
//
//   channel  dir  handshake            beat
//   in_ch    in   valid/ready          bftf_pkg::in_beat_t (poses, nominal controls)
//   out_ch   out  valid/ready          bftf_pkg::out_beat_t (controls, body errors)
//   cfg      in   cfg_we_i, no stall   cfg_idx_i selects one of six Q16.16 gains
//
// One beat enters per cycle unless the output stalls. The stages are one input
// stage, 24 CORDIC rotation stages, two for the body-frame rotate (multiply,
// round and saturate) and two for the gain matrix (multiply, sum and saturate).
// Every stage holds its own valid bit and advances when it is empty or the
// stage after it moves, so bubbles fill up under a stalled output and no
// beat is lost or repeated. Reset clears the valid bits and the gains to zero.
`default_nettype none
module body_frame_tracking_feedback_top (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  bftf_stream_if.sink                      in_ch,
  bftf_stream_if.source                    out_ch,
  input  wire                              cfg_we_i,
  input  wire [bftf_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [bftf_pkg::CfgDataW-1:0]     cfg_data_i
);
  import bftf_pkg::*;

  // gain registers; the user must write them only while the pipeline is idle (not enforced here)
  logic signed [31:0] gain_q [NumGains];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumGains; i++) gain_q[i] <= '0;
    end else if (cfg_we_i && (32'(cfg_idx_i) < NumGains)) begin
      gain_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // CORDIC -> rotate
  logic                      cor_valid, cor_ready;
  logic signed [CordicW-1:0] cor_cos, cor_sin;
  side_t                     cor_side;

  // rotate -> gain
  logic rot_valid, rot_ready;
  err_t rot_err;

  bftf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_ch.valid),
    .ready_o (in_ch.ready),
    .beat_i  (in_ch.payload),
    .valid_o (cor_valid),
    .ready_i (cor_ready),
    .cos_o   (cor_cos),
    .sin_o   (cor_sin),
    .side_o  (cor_side)
  );

  bftf_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cor_valid),
    .ready_o (cor_ready),
    .cos_i   (cor_cos),
    .sin_i   (cor_sin),
    .side_i  (cor_side),
    .valid_o (rot_valid),
    .ready_i (rot_ready),
    .err_o   (rot_err)
  );

  // last gain stage doubles as the output register
  bftf_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .ready_o (rot_ready),
    .err_i   (rot_err),
    .gain_i  (gain_q),
    .valid_o (out_ch.valid),
    .ready_i (out_ch.ready),
    .beat_o  (out_ch.payload)
  );

endmodule
`default_nettype wire
